### src/sgr_pkg.sv
// ----------------------------------------------------------------------------
// sgr_pkg: shared types and constants of the SGR and UTF-8 character parser
// Holds the byte codes recognised by the parser, the result record and the
// record that carries the results of one input byte into the output queue.
// ----------------------------------------------------------------------------
package sgr_pkg;

  localparam int MAX_CHAR_BYTES_DEF = 4;
  localparam int FIFO_DEPTH         = 4;
  localparam int FIFO_PTR_W         = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W         = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] ESC_BYTE    = 8'h1B;
  localparam logic [7:0] OPEN_BYTE   = 8'h5B;
  localparam logic [7:0] FINAL_BYTE  = 8'h6D;
  localparam logic [7:0] CODE_RESET  = 8'h30;
  localparam logic [7:0] CODE_BOLD   = 8'h31;
  localparam logic [7:0] CODE_THREE  = 8'h33;
  localparam logic [7:0] CODE_FOUR   = 8'h34;
  localparam logic [7:0] DIGIT_ZERO  = 8'h30;
  localparam logic [7:0] DIGIT_SEVEN = 8'h37;
  localparam logic [7:0] LEAD_TWO    = 8'hC0;
  localparam logic [7:0] LEAD_THREE  = 8'hE0;
  localparam logic [7:0] LEAD_FOUR   = 8'hF0;

  localparam int FLAG_BOLD   = 0;
  localparam int FLAG_ITALIC = 1;
  localparam int FLAG_UNDER  = 2;
  localparam int FLAG_FG     = 3;
  localparam int FLAG_BG     = 4;

  typedef struct packed {
    logic [31:0] char_bytes;
    logic [2:0]  byte_count;
    logic        bold;
    logic        italic;
    logic        underline;
    logic        fg_set;
    logic [2:0]  fg_color;
    logic        bg_set;
    logic [2:0]  bg_color;
    logic        last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] num;
    result_t    first;
    result_t    second;
  } res_pair_t;

endpackage

### src/sgr_in_stage.sv
// ----------------------------------------------------------------------------
// sgr_in_stage: input register
// Captures one request byte and holds it until the parser core takes it.
// ----------------------------------------------------------------------------
module sgr_in_stage import sgr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       item_valid,
  output logic [7:0] item_byte,
  input  logic       item_take
);

  logic       full;
  logic [7:0] held_byte;

  assign in_ready   = !full || item_take;
  assign item_valid = full;
  assign item_byte  = held_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= in_byte;
    end
  end

endmodule

### src/sgr_core.sv
// ----------------------------------------------------------------------------
// sgr_core: escape sequence and character grouping logic
// Holds the parse state and the character format, and works out in one pass
// the zero, one or two results that a byte causes.
// ----------------------------------------------------------------------------
module sgr_core import sgr_pkg::*; #(
  parameter int MAX_CHAR_BYTES = MAX_CHAR_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] b,
  output res_pair_t  res
);

  localparam logic [2:0] MAX_B = 3'(MAX_CHAR_BYTES);

  typedef enum logic [2:0] {
    M_IDLE,
    M_ESC,
    M_CODE1,
    M_CODE2,
    M_CODE3,
    M_UTF
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  first_code;
    logic [7:0]  second_code;
    logic [31:0] pend;
    logic [2:0]  held;
    logic [2:0]  expd;
  } st_t;

  typedef struct packed {
    st_t         st;
    logic        emit;
    logic [31:0] bytes;
    logic [2:0]  cnt;
  } step_t;

  st_t        cur;
  st_t        st_next;
  logic [4:0] attr_flags;
  logic [4:0] attr_flags_next;
  logic [2:0] fore_colour;
  logic [2:0] fore_colour_next;
  logic [2:0] back_colour;
  logic [2:0] back_colour_next;
  step_t      a;
  step_t      p;
  st_t        idle_st;

  function automatic logic [2:0] lead_len(input logic [7:0] lb);
    logic [2:0] len;
    if (lb < LEAD_TWO) begin
      len = 3'd1;
    end else if (lb < LEAD_THREE) begin
      len = 3'd2;
    end else if (lb < LEAD_FOUR) begin
      len = 3'd3;
    end else begin
      len = 3'd4;
    end
    if (len > MAX_B) begin
      len = MAX_B;
    end
    return len;
  endfunction

  function automatic step_t idle_fn(input st_t s, input logic [7:0] ib);
    step_t      r;
    logic [2:0] len;
    r       = '0;
    r.st    = s;
    len     = lead_len(ib);
    if (ib == ESC_BYTE) begin
      r.st.mode = M_ESC;
    end else if (len <= 3'd1) begin
      r.st.mode = M_IDLE;
      r.emit    = 1'b1;
      r.bytes   = {24'd0, ib};
      r.cnt     = 3'd1;
    end else begin
      r.st.pend = {24'd0, ib};
      r.st.held = 3'd1;
      r.st.expd = len;
      r.st.mode = M_UTF;
    end
    return r;
  endfunction

  function automatic step_t plain_fn(input st_t s, input logic [7:0] pb);
    step_t r;
    st_t   t;
    r    = '0;
    r.st = s;
    t    = s;
    case (s.mode)
      M_UTF: begin
        r.st.pend = s.pend | ({24'd0, pb} << {s.held[1:0], 3'd0});
        r.st.held = 3'(s.held + 3'd1);
        if (r.st.held >= s.expd || r.st.held >= 3'd4) begin
          r.emit    = 1'b1;
          r.bytes   = r.st.pend;
          r.cnt     = r.st.held;
          r.st.pend = '0;
          r.st.held = '0;
          r.st.expd = '0;
          r.st.mode = M_IDLE;
        end
      end
      M_ESC: begin
        if (pb == OPEN_BYTE) begin
          r.st.mode = M_CODE1;
        end else begin
          t.mode = M_IDLE;
          r      = idle_fn(t, pb);
        end
      end
      M_CODE1: begin
        r.st.first_code = pb;
        r.st.mode       = M_CODE2;
      end
      M_CODE2: begin
        if (pb == FINAL_BYTE) begin
          r.st.mode = M_IDLE;
        end else begin
          r.st.second_code = pb;
          r.st.mode        = M_CODE3;
        end
      end
      default: begin
        t.mode = M_IDLE;
        r      = idle_fn(t, pb);
      end
    endcase
    return r;
  endfunction

  function automatic result_t make_res(input logic [31:0] bytes, input logic [2:0] cnt,
                                       input logic last, input logic [4:0] fl,
                                       input logic [2:0] fg, input logic [2:0] bg);
    result_t r;
    r.char_bytes  = bytes;
    r.byte_count  = cnt;
    r.bold        = fl[FLAG_BOLD];
    r.italic      = fl[FLAG_ITALIC];
    r.underline   = fl[FLAG_UNDER];
    r.fg_set      = fl[FLAG_FG];
    r.fg_color    = fg;
    r.bg_set      = fl[FLAG_BG];
    r.bg_color    = bg;
    r.last_of_run = last;
    return r;
  endfunction

  always_comb begin
    idle_st      = cur;
    idle_st.mode = M_IDLE;
    a            = '0;
    a.st         = cur;
    p            = '0;
    p.st         = cur;
    if (cur.mode == M_CODE3) begin
      if (b == FINAL_BYTE) begin
        p.st.mode = M_IDLE;
      end else begin
        a = idle_fn(idle_st, cur.second_code);
        p = plain_fn(a.st, b);
      end
    end else begin
      p = plain_fn(cur, b);
    end
    st_next = p.st;
  end

  always_comb begin
    attr_flags_next  = attr_flags;
    fore_colour_next = fore_colour;
    back_colour_next = back_colour;
    if (cur.mode == M_CODE2 && b == FINAL_BYTE) begin
      case (cur.first_code)
        CODE_RESET: begin
          attr_flags_next  = '0;
          fore_colour_next = '0;
          back_colour_next = '0;
        end
        CODE_BOLD:  attr_flags_next[FLAG_BOLD]   = 1'b1;
        CODE_THREE: attr_flags_next[FLAG_ITALIC] = 1'b1;
        CODE_FOUR:  attr_flags_next[FLAG_UNDER]  = 1'b1;
        default:    attr_flags_next = attr_flags;
      endcase
    end else if (cur.mode == M_CODE3 && b == FINAL_BYTE) begin
      case (cur.first_code)
        CODE_THREE: begin
          attr_flags_next[FLAG_FG] = 1'b1;
          if (cur.second_code inside {[DIGIT_ZERO:DIGIT_SEVEN]}) begin
            fore_colour_next = cur.second_code[2:0];
          end
        end
        CODE_FOUR: begin
          attr_flags_next[FLAG_BG] = 1'b1;
          if (cur.second_code inside {[DIGIT_ZERO:DIGIT_SEVEN]}) begin
            back_colour_next = cur.second_code[2:0];
          end
        end
        default: attr_flags_next = attr_flags;
      endcase
    end
  end

  always_comb begin
    res.num    = 2'({1'b0, a.emit} + {1'b0, p.emit});
    res.second = make_res(p.bytes, p.cnt, 1'b1, attr_flags, fore_colour, back_colour);
    if (a.emit) begin
      res.first = make_res(a.bytes, a.cnt, !p.emit, attr_flags, fore_colour, back_colour);
    end else begin
      res.first = res.second;
    end
    if (!step) begin
      res.num = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.mode        <= M_IDLE;
      cur.first_code  <= '0;
      cur.second_code <= '0;
      cur.pend        <= '0;
      cur.held        <= '0;
      cur.expd        <= '0;
      attr_flags      <= '0;
      fore_colour     <= '0;
      back_colour     <= '0;
    end else if (step) begin
      cur         <= st_next;
      attr_flags  <= attr_flags_next;
      fore_colour <= fore_colour_next;
      back_colour <= back_colour_next;
    end
  end

endmodule

### src/sgr_out_fifo.sv
// ----------------------------------------------------------------------------
// sgr_out_fifo: result queue
// Registers the results of each byte, one or two at a time, and hands them
// out in order on the output channel.
// ----------------------------------------------------------------------------
module sgr_out_fifo import sgr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  res_pair_t wr,
  output logic      space,
  output logic      out_valid,
  input  logic      out_ready,
  output result_t   head
);

  result_t                mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr;
  logic [FIFO_PTR_W-1:0]  wr_ptr_one;
  logic [FIFO_PTR_W-1:0]  rd_ptr;
  logic [FIFO_CNT_W-1:0]  count;
  logic                   pop;

  assign wr_ptr_one = FIFO_PTR_W'(wr_ptr + 1'b1);
  assign out_valid  = (count != '0);
  assign pop        = out_valid && out_ready;
  assign space      = (count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= FIFO_PTR_W'(wr_ptr + wr.num);
      if (pop) begin
        rd_ptr <= FIFO_PTR_W'(rd_ptr + 1'b1);
      end
      count <= FIFO_CNT_W'(count + wr.num - {1'b0, pop});
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < FIFO_DEPTH; i++) begin
      if (wr.num != 2'd0 && wr_ptr == FIFO_PTR_W'(i)) begin
        mem[i] <= wr.first;
      end else if (wr.num == 2'd2 && wr_ptr_one == FIFO_PTR_W'(i)) begin
        mem[i] <= wr.second;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue count exceeds its depth");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    wr.num != 2'd0 |-> count <= FIFO_CNT_W'(FIFO_DEPTH - 2))
    else $error("results written without room in the queue");

  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    (pop && wr.num == 2'd0) |=> count == FIFO_CNT_W'($past(count) - 1'b1))
    else $error("queue count not reduced after a taken result");

endmodule

### src/sgr_escape_utf8_char_parser.sv
// ----------------------------------------------------------------------------
// sgr_escape_utf8_char_parser: terminal byte stream to formatted characters
// Groups a byte stream into UTF-8 characters and tags each with the SGR
// format set by earlier escape sequences.
// ----------------------------------------------------------------------------
// One byte is accepted per clock cycle. A byte is held in the input register
// until the core takes it, is parsed in a single pass and its results are
// written to a four-entry result queue, from whose head they are offered on
// the output in order. Escape bytes and the inner bytes of a character give
// no result; a broken colour sequence can give two. The input keeps taking
// bytes as long as the queue holds at most two results, so the rate is one
// byte per cycle unless the output side stalls or averages more than one
// result a byte.
module sgr_escape_utf8_char_parser import sgr_pkg::*; #(
  parameter int MAX_CHAR_BYTES = MAX_CHAR_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] char_bytes,
  output logic [2:0]  byte_count,
  output logic        bold,
  output logic        italic,
  output logic        underline,
  output logic        fg_set,
  output logic [2:0]  fg_color,
  output logic        bg_set,
  output logic [2:0]  bg_color,
  output logic        last_of_run
);

  logic       item_valid;
  logic [7:0] item_byte;
  logic       item_take;
  logic       space;
  res_pair_t  res;
  result_t    head;

  assign item_take = item_valid && space;

  sgr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .item_valid (item_valid),
    .item_byte  (item_byte),
    .item_take  (item_take)
  );

  sgr_core #(
    .MAX_CHAR_BYTES (MAX_CHAR_BYTES)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .step (item_take),
    .b    (item_byte),
    .res  (res)
  );

  sgr_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr        (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign char_bytes  = head.char_bytes;
  assign byte_count  = head.byte_count;
  assign bold        = head.bold;
  assign italic      = head.italic;
  assign underline   = head.underline;
  assign fg_set      = head.fg_set;
  assign fg_color    = head.fg_color;
  assign bg_set      = head.bg_set;
  assign bg_color    = head.bg_color;
  assign last_of_run = head.last_of_run;

endmodule

### tb/tb_sgr_escape_utf8_char_parser.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sgr_escape_utf8_char_parser: self-checking bench of the SGR character parser
// Sends a directed list of bytes and then about two thousand random bytes,
// mostly well-formed escape codes and UTF-8 characters. Every accepted byte
// is run through a predictor of the parser, and each character delivered is
// compared field by field with the oldest predicted one. Both handshakes are
// throttled at random in the first two of three phases; in the third the
// output is once held off long enough for the parser to stall its input.
// ----------------------------------------------------------------------------
module tb_sgr_escape_utf8_char_parser;
  import sgr_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_BYTES = 660;
  localparam int SETTLE_CYCLES = 10;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ESC, ST_CODE1, ST_CODE2, ST_CODE3, ST_UTF
  } parse_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       typed;
    result_t    want;
  } stim_row_t;

  localparam result_t NO_CHAR = '0;
  localparam logic [7:0] STYLE_CODES [4] = '{CODE_RESET, CODE_BOLD, CODE_THREE, CODE_FOUR};

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] char_bytes;
  logic [2:0]  byte_count;
  logic        bold;
  logic        italic;
  logic        underline;
  logic        fg_set;
  logic [2:0]  fg_color;
  logic        bg_set;
  logic [2:0]  bg_color;
  logic        last_of_run;

  parse_state_t pstate      = ST_IDLE;
  logic [7:0]   code_first  = '0;
  logic [7:0]   code_second = '0;
  logic [31:0]  glyph_acc   = '0;
  logic [2:0]   glyph_held  = '0;
  logic [2:0]   glyph_len   = '0;
  logic [4:0]   fmt_flags   = '0;
  logic [2:0]   fore_col    = '0;
  logic [2:0]   back_col    = '0;

  result_t    byte_chars[$];
  result_t    awaited_chars[$];
  logic [7:0] stream_bytes[$];
  logic       cur_typed = 1'b0;
  result_t    cur_want  = '0;

  int tx_idle_pct  = 24;
  int rx_idle_pct  = 63;
  int phase        = 0;
  int mismatches   = 0;
  int bytes_sent   = 0;
  int chars_seen   = 0;
  int double_bytes = 0;
  int directed_cnt = 0;

  sgr_escape_utf8_char_parser dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .char_bytes (char_bytes),
    .byte_count (byte_count),
    .bold       (bold),
    .italic     (italic),
    .underline  (underline),
    .fg_set     (fg_set),
    .fg_color   (fg_color),
    .bg_set     (bg_set),
    .bg_color   (bg_color),
    .last_of_run(last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic result_t bare_char(logic [31:0] bytes, logic [2:0] count);
    result_t r;
    r = '0;
    r.char_bytes = bytes;
    r.byte_count = count;
    r.last_of_run = 1'b1;
    return r;
  endfunction

  function automatic void emit_char(logic [31:0] bytes, logic [2:0] count);
    result_t r;
    r.char_bytes  = bytes;
    r.byte_count  = count;
    r.bold        = fmt_flags[FLAG_BOLD];
    r.italic      = fmt_flags[FLAG_ITALIC];
    r.underline   = fmt_flags[FLAG_UNDER];
    r.fg_set      = fmt_flags[FLAG_FG];
    r.fg_color    = fore_col;
    r.bg_set      = fmt_flags[FLAG_BG];
    r.bg_color    = back_col;
    r.last_of_run = 1'b0;
    byte_chars.push_back(r);
  endfunction

  function automatic logic [2:0] utf8_length(logic [7:0] b);
    logic [2:0] n;
    if (b < LEAD_TWO) n = 3'd1;
    else if (b < LEAD_THREE) n = 3'd2;
    else if (b < LEAD_FOUR) n = 3'd3;
    else n = 3'd4;
    if (n > 3'(MAX_CHAR_BYTES_DEF)) n = 3'(MAX_CHAR_BYTES_DEF);
    return n;
  endfunction

  function automatic void apply_style(logic [7:0] c);
    if (c == CODE_RESET) begin
      fmt_flags = '0;
      fore_col = '0;
      back_col = '0;
    end else if (c == CODE_BOLD) begin
      fmt_flags[FLAG_BOLD] = 1'b1;
    end else if (c == CODE_THREE) begin
      fmt_flags[FLAG_ITALIC] = 1'b1;
    end else if (c == CODE_FOUR) begin
      fmt_flags[FLAG_UNDER] = 1'b1;
    end
  endfunction

  function automatic void apply_colour(logic [7:0] c, logic [7:0] d);
    logic digit;
    digit = (d >= DIGIT_ZERO) && (d <= DIGIT_SEVEN);
    if (c == CODE_THREE) begin
      fmt_flags[FLAG_FG] = 1'b1;
      if (digit) fore_col = 3'(d - DIGIT_ZERO);
    end else if (c == CODE_FOUR) begin
      fmt_flags[FLAG_BG] = 1'b1;
      if (digit) back_col = 3'(d - DIGIT_ZERO);
    end
  endfunction

  function automatic void fresh_byte(logic [7:0] b);
    logic [2:0] n;
    n = utf8_length(b);
    if (b == ESC_BYTE) begin
      pstate = ST_ESC;
    end else if (n <= 3'd1) begin
      pstate = ST_IDLE;
      emit_char({24'd0, b}, 3'd1);
    end else begin
      glyph_acc = {24'd0, b};
      glyph_held = 3'd1;
      glyph_len = n;
      pstate = ST_UTF;
    end
  endfunction

  function automatic void step_byte(logic [7:0] b);
    case (pstate)
      ST_UTF: begin
        glyph_acc = glyph_acc | ({24'd0, b} << {glyph_held[1:0], 3'b000});
        glyph_held = glyph_held + 3'd1;
        if (glyph_held >= glyph_len || glyph_held >= 3'd4) begin
          emit_char(glyph_acc, glyph_held);
          glyph_acc = '0;
          glyph_held = '0;
          glyph_len = '0;
          pstate = ST_IDLE;
        end
      end
      ST_ESC: begin
        if (b == OPEN_BYTE) begin
          pstate = ST_CODE1;
        end else begin
          pstate = ST_IDLE;
          fresh_byte(b);
        end
      end
      ST_CODE1: begin
        code_first = b;
        pstate = ST_CODE2;
      end
      ST_CODE2: begin
        if (b == FINAL_BYTE) begin
          apply_style(code_first);
          pstate = ST_IDLE;
        end else begin
          code_second = b;
          pstate = ST_CODE3;
        end
      end
      default: begin
        pstate = ST_IDLE;
        fresh_byte(b);
      end
    endcase
  endfunction

  function automatic void parse_byte(logic [7:0] b);
    byte_chars = {};
    if (pstate == ST_CODE3) begin
      pstate = ST_IDLE;
      if (b == FINAL_BYTE) begin
        apply_colour(code_first, code_second);
      end else begin
        fresh_byte(code_second);
        step_byte(b);
      end
    end else begin
      step_byte(b);
    end
    if (byte_chars.size() > 0) byte_chars[byte_chars.size() - 1].last_of_run = 1'b1;
  endfunction

  function automatic logic [7:0] rnd_byte(logic [7:0] lo, logic [7:0] hi);
    return 8'($urandom_range(32'(hi), 32'(lo)));
  endfunction

  function automatic void queue_random_token();
    int pick;
    int len;
    pick = $urandom_range(99);
    if (pick < 30) begin
      stream_bytes.push_back(rnd_byte(8'h20, 8'h7E));
    end else if (pick < 50) begin
      len = $urandom_range(4, 2);
      if (len == 2) stream_bytes.push_back(rnd_byte(LEAD_TWO, LEAD_THREE - 8'd1));
      else if (len == 3) stream_bytes.push_back(rnd_byte(LEAD_THREE, LEAD_FOUR - 8'd1));
      else stream_bytes.push_back(rnd_byte(LEAD_FOUR, 8'hFF));
      for (int i = 1; i < len; i++) begin
        if ($urandom_range(7) == 0) stream_bytes.push_back(rnd_byte(8'h00, 8'hFF));
        else stream_bytes.push_back(rnd_byte(8'h80, 8'hBF));
      end
    end else if (pick < 62) begin
      stream_bytes.push_back(ESC_BYTE);
      stream_bytes.push_back(OPEN_BYTE);
      if ($urandom_range(4) == 0) stream_bytes.push_back(rnd_byte(8'h00, 8'hFF));
      else stream_bytes.push_back(STYLE_CODES[$urandom_range(3)]);
      stream_bytes.push_back(FINAL_BYTE);
    end else if (pick < 77) begin
      stream_bytes.push_back(ESC_BYTE);
      stream_bytes.push_back(OPEN_BYTE);
      if ($urandom_range(4) == 0) stream_bytes.push_back(rnd_byte(8'h00, 8'hFF));
      else stream_bytes.push_back($urandom_range(1) ? CODE_THREE : CODE_FOUR);
      if ($urandom_range(4) == 0) stream_bytes.push_back(rnd_byte(8'h00, 8'hFF));
      else stream_bytes.push_back(rnd_byte(DIGIT_ZERO, DIGIT_SEVEN));
      stream_bytes.push_back(FINAL_BYTE);
    end else if (pick < 85) begin
      stream_bytes.push_back(ESC_BYTE);
      stream_bytes.push_back(OPEN_BYTE);
      for (int i = 0; i < 3; i++) stream_bytes.push_back(rnd_byte(8'h00, 8'hFF));
    end else if (pick < 90) begin
      stream_bytes.push_back(ESC_BYTE);
      stream_bytes.push_back(rnd_byte(8'h00, 8'hFF));
    end else begin
      stream_bytes.push_back(rnd_byte(8'h00, 8'hFF));
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic compare_char(input result_t got, input result_t want);
    if (got.char_bytes !== want.char_bytes)
      report_mismatch("char_bytes", got.char_bytes, want.char_bytes);
    if (got.byte_count !== want.byte_count)
      report_mismatch("byte_count", 32'(got.byte_count), 32'(want.byte_count));
    if (got.bold !== want.bold)
      report_mismatch("bold", 32'(got.bold), 32'(want.bold));
    if (got.italic !== want.italic)
      report_mismatch("italic", 32'(got.italic), 32'(want.italic));
    if (got.underline !== want.underline)
      report_mismatch("underline", 32'(got.underline), 32'(want.underline));
    if (got.fg_set !== want.fg_set)
      report_mismatch("fg_set", 32'(got.fg_set), 32'(want.fg_set));
    if (got.fg_color !== want.fg_color)
      report_mismatch("fg_color", 32'(got.fg_color), 32'(want.fg_color));
    if (got.bg_set !== want.bg_set)
      report_mismatch("bg_set", 32'(got.bg_set), 32'(want.bg_set));
    if (got.bg_color !== want.bg_color)
      report_mismatch("bg_color", 32'(got.bg_color), 32'(want.bg_color));
    if (got.last_of_run !== want.last_of_run)
      report_mismatch("last_of_run", 32'(got.last_of_run), 32'(want.last_of_run));
  endtask

  // Called at a falling edge; returns at the falling edge after the request
  // has been taken.
  task automatic send_byte(input logic [7:0] b, input logic typed, input result_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    cur_typed = typed;
    cur_want = want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  always @(posedge clk) begin : request_monitor
    if (!rst && in_valid && in_ready) begin
      parse_byte(in_byte);
      bytes_sent++;
      if (byte_chars.size() == 2) double_bytes++;
      if (cur_typed) awaited_chars.push_back(cur_want);
      else foreach (byte_chars[i]) awaited_chars.push_back(byte_chars[i]);
    end
  end

  always @(posedge clk) begin : char_monitor
    result_t got;
    if (!rst && out_valid && out_ready) begin
      got = {char_bytes, byte_count, bold, italic, underline, fg_set, fg_color,
             bg_set, bg_color, last_of_run};
      chars_seen++;
      if (awaited_chars.size() == 0) report_mismatch("char with nothing expected",
                                                     got.char_bytes, 32'd0);
      else compare_char(got, awaited_chars.pop_front());
    end
  end

  initial begin : receiver
    int  hold_left;
    bit  held_once;
    bit  take;
    hold_left = 0;
    held_once = 1'b0;
    take = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (phase == 2 && !held_once) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      take = ($urandom_range(99) >= rx_idle_pct);
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= take;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Timed out after %0d cycles without a handshake.", STALL_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    stim_row_t rows[$];
    rst = 1'b1;
    in_valid = 1'b0;
    in_byte = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    rows = '{
      '{8'h00, 1'b1, bare_char(32'h0000_0000, 3'd1)},
      '{8'h80, 1'b1, bare_char(32'h0000_0080, 3'd1)},
      '{8'hFF, 1'b0, NO_CHAR},
      '{ESC_BYTE, 1'b0, NO_CHAR},
      '{8'h80, 1'b0, NO_CHAR},
      '{8'hBF, 1'b1, bare_char(32'hBF80_1BFF, 3'd4)},
      '{ESC_BYTE, 1'b0, NO_CHAR}, '{OPEN_BYTE, 1'b0, NO_CHAR},
      '{CODE_BOLD, 1'b0, NO_CHAR}, '{FINAL_BYTE, 1'b0, NO_CHAR},
      '{ESC_BYTE, 1'b0, NO_CHAR}, '{OPEN_BYTE, 1'b0, NO_CHAR},
      '{CODE_THREE, 1'b0, NO_CHAR}, '{DIGIT_SEVEN, 1'b0, NO_CHAR},
      '{FINAL_BYTE, 1'b0, NO_CHAR},
      '{ESC_BYTE, 1'b0, NO_CHAR}, '{OPEN_BYTE, 1'b0, NO_CHAR},
      '{CODE_FOUR, 1'b0, NO_CHAR}, '{8'h39, 1'b0, NO_CHAR},
      '{FINAL_BYTE, 1'b0, NO_CHAR},
      '{ESC_BYTE, 1'b0, NO_CHAR}, '{8'h41, 1'b0, NO_CHAR},
      '{ESC_BYTE, 1'b0, NO_CHAR}, '{OPEN_BYTE, 1'b0, NO_CHAR},
      '{CODE_THREE, 1'b0, NO_CHAR}, '{8'h41, 1'b0, NO_CHAR},
      '{8'h42, 1'b0, NO_CHAR},
      '{ESC_BYTE, 1'b0, NO_CHAR}, '{OPEN_BYTE, 1'b0, NO_CHAR},
      '{CODE_RESET, 1'b0, NO_CHAR}, '{FINAL_BYTE, 1'b0, NO_CHAR},
      '{8'h7F, 1'b1, bare_char(32'h0000_007F, 3'd1)}
    };
    foreach (rows[i]) send_byte(rows[i].data, rows[i].typed, rows[i].want);
    directed_cnt = rows.size();
    in_valid <= 1'b0;
    wait (awaited_chars.size() == 0);
    @(negedge clk);

    for (int p = 0; p < 3; p++) begin
      phase = p;
      tx_idle_pct = (p == 0) ? 24 : (p == 1) ? 63 : 0;
      rx_idle_pct = (p == 0) ? 63 : (p == 1) ? 24 : 0;
      stream_bytes = {};
      while (stream_bytes.size() < PHASE_BYTES) queue_random_token();
      foreach (stream_bytes[i]) send_byte(stream_bytes[i], 1'b0, NO_CHAR);
      in_valid <= 1'b0;
      wait (awaited_chars.size() == 0);
      @(negedge clk);
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (awaited_chars.size() != 0)
      report_mismatch("chars never delivered", 32'(awaited_chars.size()), 32'd0);
    $display("Covered %0d bytes (%0d directed, rest random over three throttling phases)",
             bytes_sent, directed_cnt);
    $display("and %0d characters, %0d bytes giving two; output held off once for %0d cycles.",
             chars_seen, double_bytes, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
